FILE: sv/aabb_pkg.sv
// ----------------------------------------------------------------------------
// AABB contact resolver package
// Shared constants and types of the resolver core and its bit-serial unit.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // Q16.16 one
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  // Register reset values
  localparam logic [16:0] RESTITUTION_RST  = 17'd32768;
  localparam logic [16:0] MASS_EPSILON_RST = 17'd7;

  // Configuration register indexes
  localparam logic REG_RESTITUTION  = 1'b0;
  localparam logic REG_MASS_EPSILON = 1'b1;

  // Normal axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } alu_op_t;

  // Request to the serial multiply/divide unit
  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // Response of the serial multiply/divide unit
  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

FILE: sv/aabb_pair_contact_resolver_core.sv
// ----------------------------------------------------------------------------
// AABB pair contact resolver
// Resolves one overlapping pair of axis-aligned boxes by least penetration,
// with position correction and a restitution impulse, in Q16.16.
// ----------------------------------------------------------------------------
// An item with second_of_pair low is held as body A and gives no result. An
// item with second_of_pair high is body B: the block resolves it against the
// held A and returns two items, A then B. A pair with contact runs the overlap
// test, up to two inverse-mass divides, a correction divide, then up to five
// multiplies and one more divide, all on one shared bit-serial multiply/divide
// unit. A pair of two sleeping bodies goes straight to the output, and a
// separated pair stops after the overlap test. Body A stays held, so further
// B items pair with the same A.
module aabb_pair_contact_resolver_core (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic               cfg_addr,
  input  logic [16:0]        cfg_wdata,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               second_of_pair,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] body_mass,
  input  logic [30:0]        size_x,
  input  logic [30:0]        size_y,
  input  logic [30:0]        size_z,
  input  logic               is_asleep,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_pos_z,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z,
  output logic               woken,
  output logic               contact,
  output logic [1:0]         normal_axis,
  output logic               normal_negative,
  output logic signed [31:0] impulse,
  output logic               last_of_pair
);
  import aabb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DELTA,
    S_OVER,
    S_PICK,
    S_INVA,
    S_INVB,
    S_SUM,
    S_CORR,
    S_MOVA,
    S_MOVB,
    S_VAN,
    S_IMPT,
    S_IMPD,
    S_VELA,
    S_VELB,
    S_OUTA,
    S_OUTB
  } state_t;

  state_t state;

  // configuration registers
  logic [16:0] restitution;
  logic [16:0] mass_epsilon;

  // held body A
  logic [31:0] held_pos [3];
  logic [31:0] held_vel [3];
  logic [30:0] held_size [3];
  logic [31:0] held_mass;
  logic        held_asleep;

  // working pair
  logic [31:0] pa [3];
  logic [31:0] va [3];
  logic [31:0] pb [3];
  logic [31:0] vb [3];
  logic [30:0] sb [3];
  logic [31:0] mb;
  logic [31:0] dl [3];
  logic [31:0] ov [3];
  logic [1:0]  axis;
  logic        neg;
  logic        hit;
  logic        touch;
  logic [31:0] pen;
  logic [31:0] inva;
  logic [31:0] invb;
  logic [31:0] invsum;
  logic [31:0] corr;
  logic [31:0] van;
  logic [31:0] tmp;
  logic [31:0] imp;
  logic        issued;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [31:0] eps_ext;
  logic        a_heavy;
  logic        b_heavy;
  logic [31:0] abs_dl;
  logic [31:0] half_sum;
  logic        all_pos;
  logic        le01;
  logic        le02;
  logic        le12;
  logic [1:0]  pick_axis;
  logic [31:0] pick_pen;
  logic        pick_neg;
  logic [31:0] sum_w;
  logic        sum_ok;
  logic [31:0] van_d;
  logic [31:0] van_n;
  logic [31:0] imp_coef;
  logic [31:0] res;
  logic [31:0] res_neg;
  logic        out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign eps_ext = {15'd0, mass_epsilon};
  assign a_heavy = $signed(held_mass) > $signed(eps_ext);
  assign b_heavy = $signed(mb) > $signed(eps_ext);

  // overlap on the current axis
  assign abs_dl   = dl[axis][31] ? 32'd0 - dl[axis] : dl[axis];
  assign half_sum = {2'd0, held_size[axis][30:1]} + {2'd0, sb[axis][30:1]};

  // least penetration axis, ties go to x then y
  assign all_pos = ($signed(ov[0]) > 0) && ($signed(ov[1]) > 0) && ($signed(ov[2]) > 0);
  assign le01    = $signed(ov[0]) <= $signed(ov[1]);
  assign le02    = $signed(ov[0]) <= $signed(ov[2]);
  assign le12    = $signed(ov[1]) <= $signed(ov[2]);
  assign pick_axis = (le01 && le02) ? AXIS_X : ((!le01 && le12) ? AXIS_Y : AXIS_Z);
  assign pick_pen  = (pick_axis == AXIS_X) ? ov[0] : ((pick_axis == AXIS_Y) ? ov[1] : ov[2]);
  assign pick_neg  = (pick_axis == AXIS_X) ? dl[0][31] :
                     ((pick_axis == AXIS_Y) ? dl[1][31] : dl[2][31]);

  assign sum_w  = inva + invb;
  assign sum_ok = $signed(sum_w) >= $signed(eps_ext);

  // approach speed along the normal
  assign van_d = va[axis] - vb[axis];
  assign van_n = neg ? 32'd0 - van_d : van_d;

  assign imp_coef = 32'd0 - (Q_ONE + {15'd0, restitution});

  assign res     = alu_rsp.result;
  assign res_neg = 32'd0 - alu_rsp.result;

  // operands for the serial unit
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_req.a     = 32'd0;
    alu_req.b     = 32'd0;
    case (state)
      S_INVA: begin
        alu_req.start = !issued && a_heavy;
        alu_req.op    = OP_DIV;
        alu_req.a     = Q_ONE;
        alu_req.b     = held_mass;
      end
      S_INVB: begin
        alu_req.start = !issued && b_heavy;
        alu_req.op    = OP_DIV;
        alu_req.a     = Q_ONE;
        alu_req.b     = mb;
      end
      S_CORR: begin
        alu_req.start = !issued;
        alu_req.op    = OP_DIV;
        alu_req.a     = pen;
        alu_req.b     = invsum;
      end
      S_MOVA, S_VELA: begin
        alu_req.start = !issued;
        alu_req.a     = corr;
        alu_req.b     = inva;
      end
      S_MOVB, S_VELB: begin
        alu_req.start = !issued;
        alu_req.a     = corr;
        alu_req.b     = invb;
      end
      S_IMPT: begin
        alu_req.start = !issued;
        alu_req.a     = imp_coef;
        alu_req.b     = van;
      end
      S_IMPD: begin
        alu_req.start = !issued;
        alu_req.op    = OP_DIV;
        alu_req.a     = tmp;
        alu_req.b     = invsum;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  aabb_serial_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // sequencer, held state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      out_valid    <= 1'b0;
      restitution  <= RESTITUTION_RST;
      mass_epsilon <= MASS_EPSILON_RST;
      for (int i = 0; i < 3; i++) begin
        held_pos[i]  <= 32'd0;
        held_vel[i]  <= 32'd0;
        held_size[i] <= 31'd0;
      end
      held_mass   <= 32'd0;
      held_asleep <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        if (cfg_addr == REG_RESTITUTION) begin
          restitution <= cfg_wdata;
        end else if (cfg_addr == REG_MASS_EPSILON) begin
          mass_epsilon <= cfg_wdata;
        end
      end

      // track an outstanding serial operation
      if (alu_req.start) begin
        issued <= 1'b1;
      end else if (alu_rsp.done) begin
        issued <= 1'b0;
      end

      // drop a taken result unless the next one is loaded now
      if (out_valid && !out_stall && (state != S_OUTA) && (state != S_OUTB)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!second_of_pair) begin
              // hold body A
              held_pos[0]  <= pos_x;
              held_pos[1]  <= pos_y;
              held_pos[2]  <= pos_z;
              held_vel[0]  <= vel_x;
              held_vel[1]  <= vel_y;
              held_vel[2]  <= vel_z;
              held_size[0] <= size_x;
              held_size[1] <= size_y;
              held_size[2] <= size_z;
              held_mass    <= body_mass;
              held_asleep  <= is_asleep;
            end else begin
              // load the pair
              for (int i = 0; i < 3; i++) begin
                pa[i] <= held_pos[i];
                va[i] <= held_vel[i];
              end
              pb[0] <= pos_x;
              pb[1] <= pos_y;
              pb[2] <= pos_z;
              vb[0] <= vel_x;
              vb[1] <= vel_y;
              vb[2] <= vel_z;
              sb[0] <= size_x;
              sb[1] <= size_y;
              sb[2] <= size_z;
              mb    <= body_mass;
              axis  <= AXIS_X;
              neg   <= 1'b0;
              hit   <= 1'b0;
              touch <= 1'b0;
              imp   <= 32'd0;
              state <= (held_asleep && is_asleep) ? S_OUTA : S_DELTA;
            end
          end
        end
        S_DELTA: begin
          dl[axis] <= pa[axis] - pb[axis];
          state    <= S_OVER;
        end
        S_OVER: begin
          ov[axis] <= half_sum - abs_dl;
          if (axis == AXIS_Z) begin
            state <= S_PICK;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DELTA;
          end
        end
        S_PICK: begin
          if (all_pos) begin
            hit   <= 1'b1;
            axis  <= pick_axis;
            pen   <= pick_pen;
            neg   <= pick_neg;
            state <= S_INVA;
          end else begin
            state <= S_OUTA;
          end
        end
        S_INVA: begin
          if (!a_heavy) begin
            inva  <= 32'd0;
            state <= S_INVB;
          end else if (alu_rsp.done) begin
            inva  <= res;
            state <= S_INVB;
          end
        end
        S_INVB: begin
          if (!b_heavy) begin
            invb  <= 32'd0;
            state <= S_SUM;
          end else if (alu_rsp.done) begin
            invb  <= res;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          invsum <= sum_w;
          if (sum_ok) begin
            touch <= 1'b1;
            state <= S_CORR;
          end else begin
            state <= S_OUTA;
          end
        end
        S_CORR: begin
          if (alu_rsp.done) begin
            corr  <= neg ? res_neg : res;
            state <= S_MOVA;
          end
        end
        S_MOVA: begin
          if (alu_rsp.done) begin
            pa[axis] <= pa[axis] + res;
            state    <= S_MOVB;
          end
        end
        S_MOVB: begin
          if (alu_rsp.done) begin
            pb[axis] <= pb[axis] - res;
            state    <= S_VAN;
          end
        end
        S_VAN: begin
          van   <= van_n;
          state <= ($signed(van_n) <= 0) ? S_IMPT : S_OUTA;
        end
        S_IMPT: begin
          if (alu_rsp.done) begin
            tmp   <= res;
            state <= S_IMPD;
          end
        end
        S_IMPD: begin
          if (alu_rsp.done) begin
            imp   <= res;
            corr  <= neg ? res_neg : res;
            state <= S_VELA;
          end
        end
        S_VELA: begin
          if (alu_rsp.done) begin
            va[axis] <= va[axis] + res;
            state    <= S_VELB;
          end
        end
        S_VELB: begin
          if (alu_rsp.done) begin
            vb[axis] <= vb[axis] - res;
            state    <= S_OUTA;
          end
        end
        S_OUTA: begin
          if (out_free) begin
            new_pos_x       <= pa[0];
            new_pos_y       <= pa[1];
            new_pos_z       <= pa[2];
            new_vel_x       <= va[0];
            new_vel_y       <= va[1];
            new_vel_z       <= va[2];
            woken           <= hit;
            contact         <= touch;
            normal_axis     <= hit ? axis : AXIS_X;
            normal_negative <= hit && neg;
            impulse         <= imp;
            last_of_pair    <= 1'b0;
            out_valid       <= 1'b1;
            state           <= S_OUTB;
          end
        end
        S_OUTB: begin
          if (out_free) begin
            new_pos_x       <= pb[0];
            new_pos_y       <= pb[1];
            new_pos_z       <= pb[2];
            new_vel_x       <= vb[0];
            new_vel_y       <= vb[1];
            new_vel_z       <= vb[2];
            last_of_pair    <= 1'b1;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/aabb_serial_alu.sv
// ----------------------------------------------------------------------------
// AABB bit-serial Q16.16 multiply/divide unit
// Multiply: shift-add one bit a cycle, result is the 64-bit product >> 16.
// Divide: restoring, one quotient bit a cycle, result is (a << 16) / b,
// truncated; a zero divisor saturates. Overflow wraps.
// ----------------------------------------------------------------------------
module aabb_serial_alu (
  input  logic               clk,
  input  logic               rst,
  input  aabb_pkg::alu_req_t req,
  output aabb_pkg::alu_rsp_t rsp
);
  import aabb_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_FIX
  } phase_t;

  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd47;

  phase_t      phase;
  alu_op_t     op_r;
  logic        neg_r;
  logic [5:0]  cnt;
  logic [31:0] hi;
  logic [47:0] lo;
  logic [31:0] mc;
  logic [31:0] result;
  logic        done;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] madd;
  logic [32:0] dtry;
  logic        dfit;
  logic [32:0] ddiff;
  logic [47:0] fix_in;
  logic [47:0] fix_out;

  // operand magnitudes
  assign mag_a = req.a[31] ? 32'd0 - req.a : req.a;
  assign mag_b = req.b[31] ? 32'd0 - req.b : req.b;

  // multiply step: add multiplicand on the low bit, then shift right
  assign madd = {1'b0, hi} + (lo[0] ? {1'b0, mc} : 33'd0);

  // divide step: shift in the next dividend bit, try to subtract
  assign dtry  = {hi, lo[47]};
  assign dfit  = dtry >= {1'b0, mc};
  assign ddiff = dtry - {1'b0, mc};

  // apply sign at the end
  assign fix_in  = (op_r == OP_MUL) ? {hi[15:0], lo[31:0]} : lo;
  assign fix_out = neg_r ? 48'd0 - fix_in : fix_in;

  assign rsp.done   = done;
  assign rsp.result = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (req.start) begin
            op_r  <= req.op;
            neg_r <= req.a[31] ^ req.b[31];
            cnt   <= 6'd0;
            hi    <= 32'd0;
            mc    <= mag_b;
            if (req.op == OP_MUL) begin
              lo    <= {16'd0, mag_a};
              phase <= PH_RUN;
            end else if (req.b == 32'd0) begin
              // saturate on a zero divisor
              result <= req.a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
              done   <= 1'b1;
            end else begin
              lo    <= {mag_a, 16'd0};
              phase <= PH_RUN;
            end
          end
        end
        PH_RUN: begin
          if (op_r == OP_MUL) begin
            hi <= madd[32:1];
            lo <= {16'd0, madd[0], lo[31:1]};
          end else begin
            hi <= dfit ? ddiff[31:0] : dtry[31:0];
            lo <= {lo[46:0], dfit};
          end
          cnt <= cnt + 6'd1;
          if (cnt == ((op_r == OP_MUL) ? MUL_LAST : DIV_LAST)) begin
            phase <= PH_FIX;
          end
        end
        PH_FIX: begin
          result <= (op_r == OP_MUL) ? fix_out[47:16] : fix_out[31:0];
          done   <= 1'b1;
          phase  <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/aabb_checker.sv
// ----------------------------------------------------------------------------
// AABB contact resolver checker
// Port-level checks of the resolver core, bound to the core module.
// ----------------------------------------------------------------------------
module aabb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               second_of_pair,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] new_pos_x,
  input logic signed [31:0] new_vel_x,
  input logic               woken,
  input logic               contact,
  input logic [1:0]         normal_axis,
  input logic               normal_negative,
  input logic signed [31:0] impulse,
  input logic               last_of_pair
);

  // hold a stalled result item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(last_of_pair) && $stable(new_pos_x)
      && $stable(new_vel_x) && $stable(impulse))
    else $error("stalled result item changed");

  // a pair without overlap reports no contact data
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !woken |-> !contact && normal_axis == 2'd0 && !normal_negative
      && impulse == 32'sd0)
    else $error("contact data on a pair without overlap");

  // an impulse needs a contact
  assert property (@(posedge clk) disable iff (rst)
    out_valid && impulse != 32'sd0 |-> contact && woken)
    else $error("impulse without contact");

  // a body B item keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && second_of_pair |=> in_stall)
    else $error("body B item did not start a pair");

endmodule

bind aabb_pair_contact_resolver_core aabb_checker u_aabb_checker (.*);
